// ===== design/agst_pkg.sv =====
// Package for the adjacency matrix graph store.
// Holds opcode and status codes and the controller/datapath handshake structs.
// No dependencies.
package agst_pkg;

   // Fixed widths of the request and response fields.
   localparam int unsigned OP_W       = 3;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned FIELD_ID_W = 32;
   localparam int unsigned DEG_OUT_W  = 6;

   // Command codes carried by a request.
   typedef enum logic [OP_W-1:0] {
      OP_INS_VERTEX = 3'd0,
      OP_INS_EDGE   = 3'd1,
      OP_ERASE_EDGE = 3'd2,
      OP_DEGREE     = 3'd3,
      OP_MIN_DEGREE = 3'd4
   } op_type;

   // Status codes carried by a response.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_EXISTS    = 3'd1,
      ST_ABSENT    = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_rd;
      logic decide;
      logic row_rd_u;
      logic check_u;
      logic row_rd_v;
      logic mod_v;
      logic rsp_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_valid;
      logic count_zero;
      logic scan_last;
      logic edge_go;
      logic edge_ok;
   } dp_stat_type;

endpackage

// ===== design/agst_if.sv =====
// Request and response channel interfaces of the graph store.
// Depends on agst_pkg for field widths.
interface agst_req_if import agst_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [OP_W-1:0]              command;
   logic signed [FIELD_ID_W-1:0] first_vertex_id;
   logic signed [FIELD_ID_W-1:0] second_vertex_id;

   modport source (output valid, command, first_vertex_id, second_vertex_id, input ready);
   modport sink (input valid, command, first_vertex_id, second_vertex_id, output ready);
endinterface

interface agst_rsp_if import agst_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [STATUS_W-1:0]          status;
   logic                         vertex_found;
   logic signed [FIELD_ID_W-1:0] result_vertex_id;
   logic [DEG_OUT_W-1:0]         degree;
   logic                         degree_odd;

   modport source (output valid, status, vertex_found, result_vertex_id, degree, degree_odd,
                   input ready);
   modport sink (input valid, status, vertex_found, result_vertex_id, degree, degree_odd,
                 output ready);
endinterface

// ===== design/agst_ctrl.sv =====
// Controller state machine of the graph store.
// Depends on agst_pkg; drives the datapath through dp_cmd_type.
module agst_ctrl import agst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_FIRST  = 10'b00_0000_0010,
      S_SCAN   = 10'b00_0000_0100,
      S_DRAIN  = 10'b00_0000_1000,
      S_DECIDE = 10'b00_0001_0000,
      S_READ_U = 10'b00_0010_0000,
      S_CHK_U  = 10'b00_0100_0000,
      S_READ_V = 10'b00_1000_0000,
      S_MOD_V  = 10'b01_0000_0000,
      S_RESP   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            if (!stat.op_valid) begin
               state_in = S_RESP;
            end else if (stat.count_zero) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = stat.edge_go ? S_READ_U : S_RESP;
         end
         S_READ_U: begin
            cmd.row_rd_u = 1'b1;
            state_in     = S_CHK_U;
         end
         S_CHK_U: begin
            cmd.check_u = 1'b1;
            state_in    = stat.edge_ok ? S_READ_V : S_RESP;
         end
         S_READ_V: begin
            cmd.row_rd_v = 1'b1;
            state_in     = S_MOD_V;
         end
         S_MOD_V: begin
            cmd.mod_v = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            // Load the output register once the previous response is gone.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/agst_dp.sv =====
// Datapath of the graph store: vertex id, degree and adjacency row memories,
// the table scan and the edge update logic. Depends on agst_pkg.
module agst_dp import agst_pkg::*; #(
   parameter int unsigned MAX_VERTICES = 64,
   parameter int unsigned ID_WIDTH     = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   output dp_stat_type                  stat,
   input  logic [OP_W-1:0]              req_command,
   input  logic signed [FIELD_ID_W-1:0] req_first_vertex_id,
   input  logic signed [FIELD_ID_W-1:0] req_second_vertex_id,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic                         rsp_vertex_found,
   output logic signed [FIELD_ID_W-1:0] rsp_result_vertex_id,
   output logic [DEG_OUT_W-1:0]         rsp_degree,
   output logic                         rsp_degree_odd
);

   localparam int unsigned SLOT_W = $clog2(MAX_VERTICES);
   localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int unsigned DEG_W  = SLOT_W;
   localparam int unsigned WIDE_W = DEG_W + DEG_OUT_W + 1;

   // Memories.
   logic signed [ID_WIDTH-1:0] ids_mem [MAX_VERTICES];
   logic [DEG_W-1:0]           deg_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0]    adj_mem [MAX_VERTICES];

   // Request registers and table state.
   logic [OP_W-1:0]            op_ff;
   logic signed [ID_WIDTH-1:0] a_ff, b_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [SLOT_W-1:0]          idx_ff;

   // Memory read data.
   logic                       rd_valid_ff;
   logic [SLOT_W-1:0]          rd_idx_ff;
   logic signed [ID_WIDTH-1:0] id_rd_ff;
   logic [DEG_W-1:0]           deg_rd_ff;
   logic [MAX_VERTICES-1:0]    row_rd_ff;

   // Scan results.
   logic                       found_a_ff, found_b_ff;
   logic [SLOT_W-1:0]          slot_a_ff, slot_b_ff;
   logic [DEG_W-1:0]           deg_a_ff, best_deg_ff;
   logic signed [ID_WIDTH-1:0] best_id_ff;

   // Result and output registers.
   logic [STATUS_W-1:0]        status_ff;
   logic                       found_ff;
   logic signed [FIELD_ID_W-1:0] rid_ff;
   logic [DEG_OUT_W-1:0]       deg_ff;
   logic                       odd_ff;
   logic [STATUS_W-1:0]        out_status_ff;
   logic                       out_found_ff;
   logic signed [FIELD_ID_W-1:0] out_rid_ff;
   logic [DEG_OUT_W-1:0]       out_deg_ff;
   logic                       out_odd_ff;

   // Combinational helpers.
   logic signed [63:0]         a_ext, b_ext, best_ext;
   logic [WIDE_W-1:0]          deg_wide;
   logic [SLOT_W-1:0]          rd_addr;
   logic                       is_edge_op, present, self_loop;
   logic                       ins_ok;
   logic                       wr_en, ids_wr_en;
   logic [SLOT_W-1:0]          wr_addr;
   logic [MAX_VERTICES-1:0]    row_wr;
   logic [DEG_W-1:0]           deg_wr, deg_step;
   logic [CNT_W-1:0]           count_last;

   // Request ids are sign-extended and then narrowed to the stored width.
   assign a_ext    = 64'(req_first_vertex_id);
   assign b_ext    = 64'(req_second_vertex_id);
   assign best_ext = 64'(best_id_ff);
   assign deg_wide = WIDE_W'(deg_a_ff);

   assign is_edge_op = (op_ff == OP_INS_EDGE) || (op_ff == OP_ERASE_EDGE);
   assign present    = row_rd_ff[slot_b_ff];
   assign self_loop  = (slot_a_ff == slot_b_ff);
   assign ins_ok     = !found_a_ff && (count_ff != CNT_W'(MAX_VERTICES));
   assign count_last = count_ff - CNT_W'(1);

   // Status toward the controller.
   assign stat.op_valid   = (op_ff <= OP_MIN_DEGREE);
   assign stat.count_zero = (count_ff == '0);
   assign stat.scan_last  = (idx_ff == count_last[SLOT_W-1:0]);
   assign stat.edge_go    = is_edge_op && found_a_ff && found_b_ff;
   assign stat.edge_ok    = (op_ff == OP_INS_EDGE) ? !present : present;

   // Read address: the scan index, or an edge endpoint.
   always_comb begin
      if (cmd.row_rd_u) begin
         rd_addr = slot_a_ff;
      end else if (cmd.row_rd_v) begin
         rd_addr = slot_b_ff;
      end else begin
         rd_addr = idx_ff;
      end
   end

   // Write port: clear a new slot, or update one endpoint of an edge.
   always_comb begin
      wr_en     = 1'b0;
      ids_wr_en = 1'b0;
      wr_addr   = slot_a_ff;
      row_wr    = row_rd_ff;
      deg_step  = self_loop ? '0 : DEG_W'(1);
      deg_wr    = (op_ff == OP_INS_EDGE) ? deg_rd_ff + deg_step : deg_rd_ff - deg_step;
      if (cmd.decide && (op_ff == OP_INS_VERTEX) && ins_ok) begin
         wr_en     = 1'b1;
         ids_wr_en = 1'b1;
         wr_addr   = count_ff[SLOT_W-1:0];
         row_wr    = '0;
         deg_wr    = '0;
      end else if (cmd.check_u && stat.edge_ok) begin
         wr_en               = 1'b1;
         wr_addr             = slot_a_ff;
         row_wr[slot_b_ff]   = (op_ff == OP_INS_EDGE);
      end else if (cmd.mod_v) begin
         wr_en               = 1'b1;
         wr_addr             = slot_b_ff;
         row_wr[slot_a_ff]   = (op_ff == OP_INS_EDGE);
      end
   end

   // Memory ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_mem[wr_addr] <= row_wr;
         deg_mem[wr_addr] <= deg_wr;
      end
      if (ids_wr_en) begin
         ids_mem[wr_addr] <= a_ff;
      end
      id_rd_ff  <= ids_mem[rd_addr];
      deg_rd_ff <= deg_mem[rd_addr];
      row_rd_ff <= adj_mem[rd_addr];
      rd_idx_ff <= idx_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_rd;
         if (ids_wr_en) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // Request capture, scan compare and result building.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_command;
         a_ff       <= a_ext[ID_WIDTH-1:0];
         b_ff       <= b_ext[ID_WIDTH-1:0];
         idx_ff     <= '0;
         found_a_ff <= 1'b0;
         found_b_ff <= 1'b0;
         status_ff  <= ST_OK;
         found_ff   <= 1'b0;
         rid_ff     <= '0;
         deg_ff     <= '0;
         odd_ff     <= 1'b0;
      end
      if (cmd.scan_rd) begin
         idx_ff <= idx_ff + SLOT_W'(1);
      end
      // One table entry per cycle: id match and running minimum.
      if (rd_valid_ff) begin
         if (id_rd_ff == a_ff) begin
            found_a_ff <= 1'b1;
            slot_a_ff  <= rd_idx_ff;
            deg_a_ff   <= deg_rd_ff;
         end
         if (id_rd_ff == b_ff) begin
            found_b_ff <= 1'b1;
            slot_b_ff  <= rd_idx_ff;
         end
         if ((rd_idx_ff == '0) || (deg_rd_ff < best_deg_ff) ||
             ((deg_rd_ff == best_deg_ff) && (id_rd_ff < best_id_ff))) begin
            best_deg_ff <= deg_rd_ff;
            best_id_ff  <= id_rd_ff;
         end
      end
      // Outcome once the scan is done.
      if (cmd.decide) begin
         case (op_ff)
            OP_INS_VERTEX: begin
               if (found_a_ff) begin
                  status_ff <= ST_EXISTS;
               end else if (!ins_ok) begin
                  status_ff <= ST_FULL;
               end
            end
            OP_INS_EDGE, OP_ERASE_EDGE: begin
               if (!(found_a_ff && found_b_ff)) begin
                  status_ff <= ST_NOT_FOUND;
               end
            end
            OP_DEGREE: begin
               if (!found_a_ff) begin
                  status_ff <= ST_NOT_FOUND;
               end else begin
                  deg_ff <= (deg_wide > WIDE_W'(63)) ? DEG_OUT_W'(63) : deg_wide[DEG_OUT_W-1:0];
                  odd_ff <= deg_a_ff[0];
               end
            end
            OP_MIN_DEGREE: begin
               if ((count_ff != '0) && (best_deg_ff != '0)) begin
                  found_ff <= 1'b1;
                  rid_ff   <= best_ext[FIELD_ID_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
      // Edge check against the first endpoint's row.
      if (cmd.check_u && !stat.edge_ok) begin
         status_ff <= (op_ff == OP_INS_EDGE) ? ST_EXISTS : ST_ABSENT;
      end
      if (cmd.rsp_load) begin
         out_status_ff <= status_ff;
         out_found_ff  <= found_ff;
         out_rid_ff    <= rid_ff;
         out_deg_ff    <= deg_ff;
         out_odd_ff    <= odd_ff;
      end
   end

   assign rsp_status           = out_status_ff;
   assign rsp_vertex_found     = out_found_ff;
   assign rsp_result_vertex_id = out_rid_ff;
   assign rsp_degree           = out_deg_ff;
   assign rsp_degree_odd       = out_odd_ff;

endmodule

// ===== design/adjacency_matrix_graph_store.sv =====
// Top level of the undirected graph store (adjacency matrix form).
// Depends on agst_pkg, agst_if, agst_ctrl and agst_dp.
//
//   Channel   Direction   Carries
//   req_bus   in          command, first_vertex_id, second_vertex_id
//   rsp_bus   out         status, vertex_found, result_vertex_id, degree, degree_odd
//
// A request scans the stored vertices of the id table one entry per cycle through
// the single read port of the id and degree memories; an edge update then reads
// and writes the rows of both endpoints.
// Reset is synchronous and empties the table; a new slot is cleared when filled.
// A finished response waits in the output register while the next request is taken.
module adjacency_matrix_graph_store import agst_pkg::*; #(
   parameter int unsigned MAX_VERTICES = 64,
   parameter int unsigned ID_WIDTH     = 32
) (
   input logic       clock,
   input logic       reset,
   agst_req_if.sink  req_bus,
   agst_rsp_if.source rsp_bus
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   agst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   agst_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .ID_WIDTH     (ID_WIDTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_command          (req_bus.command),
      .req_first_vertex_id  (req_bus.first_vertex_id),
      .req_second_vertex_id (req_bus.second_vertex_id),
      .rsp_status           (rsp_bus.status),
      .rsp_vertex_found     (rsp_bus.vertex_found),
      .rsp_result_vertex_id (rsp_bus.result_vertex_id),
      .rsp_degree           (rsp_bus.degree),
      .rsp_degree_odd       (rsp_bus.degree_odd)
   );

endmodule

// ===== sim/agst_tb_if.sv =====
// Testbench types for the graph store: one stored request and one expected response.
// The channel interfaces themselves come from the design folder. Depends on agst_pkg.
`timescale 1ns / 1ps
package agst_tb_types;
   import agst_pkg::*;
   // One graph request as the testbench stores it.
   typedef struct {
      logic [OP_W-1:0]              command;
      logic signed [FIELD_ID_W-1:0] first_id;
      logic signed [FIELD_ID_W-1:0] second_id;
   } graph_request_type;
   // One expected response.
   typedef struct {
      logic [STATUS_W-1:0]          status;
      logic                         found;
      logic signed [FIELD_ID_W-1:0] vertex_id;
      logic [DEG_OUT_W-1:0]         degree;
      logic                         odd;
   } graph_response_type;
endpackage

// ===== sim/testbench.sv =====
// Testbench for the adjacency matrix graph store.
// Predicts each response from a local graph model and checks every field.
// Depends on agst_pkg, agst_if, agst_tb_types and the design files.
`timescale 1ns / 1ps
module testbench;
   import agst_pkg::*;
   import agst_tb_types::*;

   localparam int NV = 64;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_OFF_LEN = 400;
   // Command codes with no operation behind them.
   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   agst_req_if req_bus ();
   agst_rsp_if rsp_bus ();

   adjacency_matrix_graph_store i_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   always #6 clock = ~clock;

   // Graph model state.
   logic signed [31:0] model_ids [NV];
   int                 model_count;
   logic [NV-1:0]      model_rows [NV];
   int                 model_degree [NV];
   graph_response_type pending_responses [$];

   int   sender_idle_pct = 0;
   int   receiver_stall_pct = 0;
   int   hold_off_cycles = 0;
   logic hold_off_go = 1'b0;
   logic hold_off_seen = 1'b0;
   int   error_count = 0;
   int   cycle_count = 0;

   function automatic int slot_of(logic signed [31:0] id);
      for (int i = 0; i < model_count; i++)
         if (model_ids[i] == id) return i;
      return -1;
   endfunction

   // Apply one request to the graph model and return the expected response.
   function automatic graph_response_type apply_graph_request(graph_request_type r);
      graph_response_type e;
      int sa, sb, best;
      logic present;
      e = '{default: '0};
      sa = slot_of(r.first_id);
      sb = slot_of(r.second_id);
      case (r.command)
         OP_INS_VERTEX: begin
            if (sa >= 0) e.status = ST_EXISTS;
            else if (model_count >= NV) e.status = ST_FULL;
            else begin
               model_ids[model_count] = r.first_id;
               model_count++;
            end
         end
         OP_INS_EDGE, OP_ERASE_EDGE: begin
            if (sa < 0 || sb < 0) e.status = ST_NOT_FOUND;
            else begin
               present = model_rows[sa][sb];
               if (r.command == OP_INS_EDGE && present) e.status = ST_EXISTS;
               else if (r.command == OP_ERASE_EDGE && !present) e.status = ST_ABSENT;
               else begin
                  model_rows[sa][sb] = (r.command == OP_INS_EDGE);
                  model_rows[sb][sa] = (r.command == OP_INS_EDGE);
                  if (sa != sb) begin
                     model_degree[sa] += (r.command == OP_INS_EDGE) ? 1 : -1;
                     model_degree[sb] += (r.command == OP_INS_EDGE) ? 1 : -1;
                  end
               end
            end
         end
         OP_DEGREE: begin
            if (sa < 0) e.status = ST_NOT_FOUND;
            else begin
               e.degree = (model_degree[sa] > 63) ? 6'd63 : model_degree[sa][5:0];
               e.odd = model_degree[sa][0];
            end
         end
         OP_MIN_DEGREE: begin
            if (model_count > 0) begin
               best = 0;
               for (int i = 1; i < model_count; i++)
                  if (model_degree[i] < model_degree[best] ||
                      (model_degree[i] == model_degree[best] &&
                       model_ids[i] < model_ids[best]))
                     best = i;
               if (model_degree[best] != 0) begin
                  e.found = 1'b1;
                  e.vertex_id = model_ids[best];
               end
            end
         end
         default: ;
      endcase
      return e;
   endfunction

   // Send one request, predicting its response at acceptance.
   // The valid line stays high after acceptance until the next request or a drain.
   task automatic send_request(logic [2:0] cmd, logic signed [31:0] a, logic signed [31:0] b);
      graph_request_type r;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      r.command = cmd;
      r.first_id = a;
      r.second_id = b;
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.first_vertex_id <= a;
      req_bus.second_vertex_id <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_responses.insert(pending_responses.size(), apply_graph_request(r));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_responses.size() != 0) @(negedge clock);
      repeat (NV + 20) @(negedge clock);
   endtask

   // Receiver ready: random stalls plus a long hold-off when one is started.
   always @(negedge clock) begin
      if (hold_off_go != hold_off_seen) begin
         hold_off_seen <= hold_off_go;
         hold_off_cycles <= HOLD_OFF_LEN - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      graph_response_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_responses.size() == 0) begin
            $error("response with nothing expected");
            error_count++;
         end else begin
            e = pending_responses.pop_front();
            if (rsp_bus.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.vertex_found !== e.found) begin
               $error("vertex_found expected %0d actual %0d", e.found, rsp_bus.vertex_found);
               error_count++;
            end
            if (rsp_bus.result_vertex_id !== e.vertex_id) begin
               $error("result_vertex_id expected %0d actual %0d", e.vertex_id,
                      rsp_bus.result_vertex_id);
               error_count++;
            end
            if (rsp_bus.degree !== e.degree) begin
               $error("degree expected %0d actual %0d", e.degree, rsp_bus.degree);
               error_count++;
            end
            if (rsp_bus.degree_odd !== e.odd) begin
               $error("degree_odd expected %0d actual %0d", e.odd, rsp_bus.degree_odd);
               error_count++;
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Pick an id: mostly from a small pool so lookups hit, sometimes extreme or random.
   function automatic logic signed [31:0] pick_id();
      int k;
      k = $urandom_range(99);
      if (k < 80) return $signed(32'($urandom_range(40))) - 20;
      if (k < 85) return 32'sh7FFFFFFF;
      if (k < 90) return 32'sh80000000;
      return $signed($urandom());
   endfunction

   // Directed checks: empty table, extremes, duplicates, self-loops, unknown ids.
   task automatic test_directed();
      send_request(OP_MIN_DEGREE, 0, 0);
      send_request(OP_DEGREE, 5, 0);
      send_request(OP_INS_VERTEX, 32'sh7FFFFFFF, 0);
      send_request(OP_INS_VERTEX, 32'sh80000000, 0);
      send_request(OP_INS_VERTEX, -1, 0);
      send_request(OP_INS_VERTEX, -1, 0);
      send_request(OP_MIN_DEGREE, 0, 0);
      send_request(OP_INS_EDGE, 32'sh7FFFFFFF, 32'sh80000000);
      send_request(OP_INS_EDGE, 32'sh80000000, 32'sh7FFFFFFF);
      send_request(OP_INS_EDGE, -1, -1);
      send_request(OP_DEGREE, -1, 0);
      send_request(OP_INS_EDGE, -1, 32'sh7FFFFFFF);
      send_request(OP_DEGREE, 32'sh7FFFFFFF, 0);
      send_request(OP_INS_EDGE, -1, 77);
      send_request(OP_MIN_DEGREE, 0, 0);
      send_request(OP_ERASE_EDGE, -1, -1);
      send_request(OP_ERASE_EDGE, -1, -1);
      send_request(OP_ERASE_EDGE, 32'sh80000000, -1);
      send_request(OP_UNUSED_FIRST, 1, 2);
      send_request(OP_UNUSED_LAST, -1, -1);
      send_request(OP_MIN_DEGREE, 0, 0);
   endtask

   // Fill the table to its limit, then one more insert reports full.
   task automatic test_table_full();
      for (int i = 0; i <= NV; i++) send_request(OP_INS_VERTEX, 1000 + i * 7, 0);
      send_request(OP_INS_EDGE, 1000, 1007);
      send_request(OP_MIN_DEGREE, 0, 0);
   endtask

   // Random mix, mostly edge work between known vertices.
   task automatic test_random(int count);
      int k;
      logic [2:0] cmd;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(99);
         if (k < 10) cmd = OP_INS_VERTEX;
         else if (k < 45) cmd = OP_INS_EDGE;
         else if (k < 65) cmd = OP_ERASE_EDGE;
         else if (k < 82) cmd = OP_DEGREE;
         else if (k < 97) cmd = OP_MIN_DEGREE;
         else cmd = 3'($urandom_range(7));
         send_request(cmd, pick_id(), pick_id());
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.command = '0;
      req_bus.first_vertex_id = '0;
      req_bus.second_vertex_id = '0;
      model_count = 0;
      for (int i = 0; i < NV; i++) begin
         model_ids[i] = '0;
         model_rows[i] = '0;
         model_degree[i] = 0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(500);
      sender_idle_pct = 53;
      test_random(350);
      sender_idle_pct = 0;
      receiver_stall_pct = 53;
      test_random(350);
      // Long receiver hold-off while requests keep coming.
      wait_drained();
      hold_off_go <= ~hold_off_go;
      test_random(20);
      sender_idle_pct = 26;
      receiver_stall_pct = 26;
      test_random(350);
      wait_drained();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      test_table_full();
      test_random(60);
      wait_drained();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
